FILE: hdl/sfcb_pkg.sv
// Package for the sensor frame CRC-16 builder: frame constants, job type
// and the byte-wise CRC-16/MODBUS update. No dependencies.
package sfcb_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned PAYLOAD_W = 4 * SAMPLE_W;
  localparam int unsigned IDX_W     = 4;

  localparam logic [7:0]  FRAME_START = 8'hAA;
  localparam logic [7:0]  FRAME_END   = 8'h55;
  localparam logic [7:0]  TYPE_QUAT   = 8'h01;
  localparam logic [7:0]  TYPE_LOAD   = 8'h02;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam logic [IDX_W-1:0] LAST_QUAT = 4'd12;
  localparam logic [IDX_W-1:0] LAST_LOAD = 4'd6;

  localparam logic KIND_QUAT = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Data bytes in transmit order from the top byte down.
  typedef struct packed {
    logic                 is_load;
    logic [PAYLOAD_W-1:0] payload;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/sensor_frame_crc16_builder_core.sv
// Top level of the sensor frame CRC-16 builder.
// Depends on sfcb_pkg, sfcb_front, sfcb_queue and sfcb_back.
//
// Usage:
//   Slave side takes one sample word per handshake: s_tuser selects the
//   frame kind (0 quaternion, 1 load), s_tdata carries the 16-bit values.
//   Master side sends the frame one byte per word: start 0xAA, type,
//   values high byte first, CRC-16/MODBUS low byte first, end 0x55 with
//   m_tlast set. Quaternion frames are 13 words, load frames 7 words.
//   When the block is empty, the first byte of a frame passes through the
//   front register, the queue, the back stage's active state and the output
//   register. Throughput: one byte per cycle while m_tready is high; frames
//   follow with no gap. The byte serializer in the back stage sets this rate.
//   The front register and the two-entry queue let up to three samples
//   wait while a frame is sent. When m_tready is low the output word holds
//   and the front keeps accepting until the queue and front register fill.
//   Reset (rst, synchronous) empties the queue and drops any frame in flight.
module sensor_frame_crc16_builder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z, load_value
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // frame_byte
  output logic        m_tlast
);

  logic           f_valid;
  logic           f_ready;
  sfcb_pkg::job_t f_job;
  logic           q_valid;
  logic           q_ready;
  sfcb_pkg::job_t q_job;

  sfcb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  sfcb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_job    (f_job),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_job   (q_job)
  );

  sfcb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

`ifndef SYNTHESIS
  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == sfcb_pkg::FRAME_END)
    else $error("last word is not the end byte");

  a_start_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> m_tdata == sfcb_pkg::FRAME_START)
    else $error("frame does not open with the start byte");

  a_queue_full_has_data: assert property (@(posedge clk) disable iff (rst)
    !f_ready |-> q_valid)
    else $error("queue full but reports no data");
`endif

endmodule

FILE: hdl/sfcb_front.sv
// Front stage: takes a sample word, classifies it and builds a job.
// Depends on sfcb_pkg.
module sfcb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [79:0]         s_tdata,
  input  logic                s_tuser,
  output logic                job_valid,
  input  logic                job_ready,
  output sfcb_pkg::job_t      job
);

  sfcb_pkg::job_t job_next;

  assign s_tready = !job_valid || job_ready;

  always_comb begin
    job_next.is_load = (s_tuser == sfcb_pkg::KIND_LOAD);
    if (job_next.is_load) begin
      job_next.payload = {s_tdata[79:64], 48'h0};
    end else begin
      job_next.payload = {s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[63:48]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (s_tready) begin
      job_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      job <= job_next;
    end
  end

endmodule

FILE: hdl/sfcb_queue.sv
// Two-entry job queue between the front and back stages.
// Depends on sfcb_pkg.
module sfcb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sfcb_pkg::job_t in_job,
  output logic           out_valid,
  input  logic           out_ready,
  output sfcb_pkg::job_t out_job
);

  sfcb_pkg::job_t entries [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= in_job;
    end
  end

endmodule

FILE: hdl/sfcb_back.sv
// Back stage: serializes one job into frame bytes with a running CRC.
// Depends on sfcb_pkg.
module sfcb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  sfcb_pkg::job_t job,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast
);

  logic                            active;
  logic [sfcb_pkg::IDX_W-1:0]      idx;
  logic                            is_load;
  logic [sfcb_pkg::PAYLOAD_W-1:0]  shift;
  logic [15:0]                     crc;
  logic [sfcb_pkg::IDX_W-1:0]      last_idx;
  logic [sfcb_pkg::IDX_W-1:0]      crc_lo_idx;
  logic [7:0]                      byte_sel;
  logic                            advance;

  assign advance    = !m_tvalid || m_tready;
  assign last_idx   = is_load ? sfcb_pkg::LAST_LOAD : sfcb_pkg::LAST_QUAT;
  assign crc_lo_idx = last_idx - 4'd2;
  assign job_ready  = advance && (!active || idx == last_idx);

  always_comb begin
    priority if (idx == 4'd0) begin
      byte_sel = sfcb_pkg::FRAME_START;
    end else if (idx == 4'd1) begin
      byte_sel = is_load ? sfcb_pkg::TYPE_LOAD : sfcb_pkg::TYPE_QUAT;
    end else if (idx == last_idx) begin
      byte_sel = sfcb_pkg::FRAME_END;
    end else if (idx == crc_lo_idx) begin
      byte_sel = crc[7:0];
    end else if (idx == last_idx - 4'd1) begin
      byte_sel = crc[15:8];
    end else begin
      byte_sel = shift[sfcb_pkg::PAYLOAD_W-1 -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= active;
      if (job_ready && job_valid) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (active) begin
        idx <= idx + 4'd1;
        if (idx == last_idx) active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && active) begin
      m_tdata <= byte_sel;
      m_tlast <= (idx == last_idx);
      if (idx == 4'd0) begin
        crc <= sfcb_pkg::crc_byte(sfcb_pkg::CRC_INIT, byte_sel);
      end else if (idx < crc_lo_idx) begin
        crc <= sfcb_pkg::crc_byte(crc, byte_sel);
      end
      if (idx >= 4'd2 && idx < crc_lo_idx) begin
        shift <= shift << 8;
      end
    end
    if (job_ready && job_valid) begin
      is_load <= job.is_load;
      shift   <= job.payload;
    end
  end

endmodule
